// ===== rtl/bprf_pkg.sv =====
// shared types and constants for the byte plane point read and rectangle fill block
package bprf_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 256;
   localparam int MAX_HEIGHT_DEFAULT = 256;

   localparam int COORD_W   = 16;
   localparam int DATA_W    = 8;
   localparam int SIZE_W    = 9;
   localparam int PROD_W    = 2 * SIZE_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   localparam logic [CSR_IDX_W-1:0] REG_PLANE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_HEIGHT = 1'b1;

   localparam logic CMD_READ = 1'b0;
   localparam logic CMD_FILL = 1'b1;

   localparam logic STATUS_DONE         = 1'b0;
   localparam logic STATUS_OUT_OF_RANGE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_BASE,
      ST_READ,
      ST_RDATA,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic eval;
      logic base;
      logic read_latch;
      logic fill_step;
      logic clear_step;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic out_of_range;
      logic is_fill;
      logic empty;
      logic col_last;
      logic row_last;
      logic clear_last;
      logic rsp_free;
   } dp_sts_type;

endpackage

// ===== rtl/bprf_datapath.sv =====
// datapath: size registers, word registers, address arithmetic, plane memory, output register
module bprf_datapath #(
   parameter int MAX_WIDTH  = bprf_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bprf_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [bprf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bprf_pkg::SIZE_W-1:0]          csr_write_data,
   input  logic                                 req_command,
   input  logic [bprf_pkg::COORD_W-1:0]         req_x,
   input  logic [bprf_pkg::COORD_W-1:0]         req_y,
   input  logic [bprf_pkg::COORD_W-1:0]         req_rect_width,
   input  logic [bprf_pkg::COORD_W-1:0]         req_rect_height,
   input  logic [bprf_pkg::DATA_W-1:0]          req_fill_value,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [bprf_pkg::DATA_W-1:0]          rsp_read_value,
   output logic                                 rsp_status,
   input  bprf_pkg::dp_cmd_type                 cmd,
   output bprf_pkg::dp_sts_type                 sts
);

   localparam longint DEPTH  = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
   localparam int     ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [bprf_pkg::SIZE_W-1:0]  width_ff, height_ff;
   logic [bprf_pkg::SIZE_W-1:0]  eff_w, eff_h;

   logic                         cmd_ff;
   logic [bprf_pkg::COORD_W-1:0] x_ff, y_ff, rw_ff, rh_ff;
   logic [bprf_pkg::DATA_W-1:0]  val_ff;

   logic [bprf_pkg::PROD_W-1:0]  prod_ff;
   logic [bprf_pkg::SIZE_W-1:0]  cw_ff, ch_ff, col_ff, row_ff;
   logic [ADDR_W-1:0]            addr_ff, row_base_ff;
   logic [bprf_pkg::DATA_W-1:0]  rd_data_ff;
   logic [bprf_pkg::DATA_W-1:0]  res_value_ff;
   logic                         res_status_ff;
   logic                         rsp_valid_ff;
   logic [bprf_pkg::DATA_W-1:0]  rsp_value_ff;
   logic                         rsp_status_ff;

   logic [bprf_pkg::SIZE_W-1:0]  span_w, span_h, clip_w, clip_h;
   logic [ADDR_W-1:0]            base_sum, row_next;
   logic                         mem_we;
   logic [bprf_pkg::DATA_W-1:0]  mem_wdata;

   logic [bprf_pkg::DATA_W-1:0]  plane_mem [DEPTH];

   // zero reads as one, anything above the store's extent as the extent
   always_comb begin
      if (width_ff == '0) begin
         eff_w = bprf_pkg::SIZE_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         eff_w = bprf_pkg::SIZE_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = bprf_pkg::SIZE_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         eff_h = bprf_pkg::SIZE_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   // x and y fit in the size width whenever they are inside the plane
   assign span_w   = eff_w - x_ff[bprf_pkg::SIZE_W-1:0];
   assign span_h   = eff_h - y_ff[bprf_pkg::SIZE_W-1:0];
   assign clip_w   = (rw_ff < bprf_pkg::COORD_W'(span_w)) ? rw_ff[bprf_pkg::SIZE_W-1:0] : span_w;
   assign clip_h   = (rh_ff < bprf_pkg::COORD_W'(span_h)) ? rh_ff[bprf_pkg::SIZE_W-1:0] : span_h;
   assign base_sum = ADDR_W'(prod_ff + bprf_pkg::PROD_W'(x_ff[bprf_pkg::SIZE_W-1:0]));
   assign row_next = row_base_ff + ADDR_W'(eff_w);

   assign mem_we    = cmd.clear_step || cmd.fill_step;
   assign mem_wdata = cmd.clear_step ? '0 : val_ff;

   assign sts.out_of_range = (x_ff >= bprf_pkg::COORD_W'(eff_w)) ||
                             (y_ff >= bprf_pkg::COORD_W'(eff_h));
   assign sts.is_fill      = (cmd_ff == bprf_pkg::CMD_FILL);
   assign sts.empty        = (cw_ff == '0) || (ch_ff == '0);
   assign sts.col_last     = (col_ff == cw_ff - bprf_pkg::SIZE_W'(1));
   assign sts.row_last     = (row_ff == ch_ff - bprf_pkg::SIZE_W'(1));
   assign sts.clear_last   = (addr_ff == ADDR_W'(DEPTH - 1));
   assign sts.rsp_free     = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         plane_mem[addr_ff] <= mem_wdata;
      end
      rd_data_ff <= plane_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bprf_pkg::SIZE_RESET;
         height_ff    <= bprf_pkg::SIZE_RESET;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == bprf_pkg::REG_PLANE_WIDTH) begin
            width_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == bprf_pkg::REG_PLANE_HEIGHT) begin
            height_ff <= csr_write_data;
         end
         if (cmd.clear_step) begin
            addr_ff <= addr_ff + ADDR_W'(1);
         end else if (cmd.base) begin
            addr_ff <= base_sum;
         end else if (cmd.fill_step) begin
            addr_ff <= sts.col_last ? row_next : addr_ff + ADDR_W'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff <= req_command;
         x_ff   <= req_x;
         y_ff   <= req_y;
         rw_ff  <= req_rect_width;
         rh_ff  <= req_rect_height;
         val_ff <= req_fill_value;
      end
      if (cmd.eval) begin
         prod_ff       <= bprf_pkg::PROD_W'(y_ff[bprf_pkg::SIZE_W-1:0]) *
                          bprf_pkg::PROD_W'(eff_w);
         cw_ff         <= clip_w;
         ch_ff         <= clip_h;
         res_value_ff  <= '0;
         res_status_ff <= sts.out_of_range ? bprf_pkg::STATUS_OUT_OF_RANGE
                                           : bprf_pkg::STATUS_DONE;
      end
      if (cmd.base) begin
         row_base_ff <= base_sum;
         col_ff      <= '0;
         row_ff      <= '0;
      end
      if (cmd.fill_step) begin
         if (sts.col_last) begin
            row_base_ff <= row_next;
            col_ff      <= '0;
            row_ff      <= row_ff + bprf_pkg::SIZE_W'(1);
         end else begin
            col_ff <= col_ff + bprf_pkg::SIZE_W'(1);
         end
      end
      if (cmd.read_latch) begin
         res_value_ff <= rd_data_ff;
      end
      if (cmd.load_rsp) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== rtl/bprf_controller.sv =====
// controller: sequences the clearing pass, point reads and rectangle fills
module bprf_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output bprf_pkg::dp_cmd_type  cmd,
   input  bprf_pkg::dp_sts_type  sts
);

   bprf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bprf_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != bprf_pkg::ST_IDLE);
      case (state_ff)
         bprf_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = bprf_pkg::ST_IDLE;
            end
         end
         bprf_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = bprf_pkg::ST_EVAL;
            end
         end
         bprf_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.out_of_range ? bprf_pkg::ST_DONE : bprf_pkg::ST_BASE;
         end
         bprf_pkg::ST_BASE: begin
            cmd.base = 1'b1;
            if (!sts.is_fill) begin
               state_in = bprf_pkg::ST_READ;
            end else if (sts.empty) begin
               state_in = bprf_pkg::ST_DONE;
            end else begin
               state_in = bprf_pkg::ST_FILL;
            end
         end
         bprf_pkg::ST_READ: begin
            // memory output lands in its register at the end of this cycle
            state_in = bprf_pkg::ST_RDATA;
         end
         bprf_pkg::ST_RDATA: begin
            cmd.read_latch = 1'b1;
            state_in       = bprf_pkg::ST_DONE;
         end
         bprf_pkg::ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.col_last && sts.row_last) begin
               state_in = bprf_pkg::ST_DONE;
            end
         end
         bprf_pkg::ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = bprf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bprf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/byte_plane_point_read_rect_fill_top.sv =====
// Byte plane of MAX_WIDTH x MAX_HEIGHT bytes in a single-port memory, stored row-major with
// the configured plane width as stride. After reset the block runs a clearing pass over all
// MAX_WIDTH * MAX_HEIGHT bytes with req_stall high; csr writes are taken throughout. A point
// read passes through EVAL, BASE, READ, RDATA and DONE from acceptance until its word is
// loaded into the output register, a point or origin outside the plane through EVAL and
// DONE, a fill through EVAL, BASE, one FILL step per clipped byte and DONE, because the
// single memory port writes one byte per cycle. One item is in work at a time; the next is
// accepted in the cycle after the previous word is loaded into the output register, and
// this holds even while that word waits on rsp_stall.
module byte_plane_point_read_rect_fill_top #(
   parameter int MAX_WIDTH  = bprf_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bprf_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [bprf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bprf_pkg::SIZE_W-1:0]      csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [bprf_pkg::COORD_W-1:0]     req_x,
   input  logic [bprf_pkg::COORD_W-1:0]     req_y,
   input  logic [bprf_pkg::COORD_W-1:0]     req_rect_width,
   input  logic [bprf_pkg::COORD_W-1:0]     req_rect_height,
   input  logic [bprf_pkg::DATA_W-1:0]      req_fill_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bprf_pkg::DATA_W-1:0]      rsp_read_value,
   output logic                             rsp_status
);

   bprf_pkg::dp_cmd_type cmd;
   bprf_pkg::dp_sts_type sts;

   bprf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   bprf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_x            (req_x),
      .req_y            (req_y),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_fill_value   (req_fill_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .sts              (sts)
   );

   // clearing pass holds off requests straight after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request accepted before the clearing pass");

   // the memory port has one writer at a time and no accept during a write
   a_one_mem_user: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.fill_step, cmd.accept}))
      else $error("memory port commands overlap");

   // a word is only loaded when the output register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.rsp_free)
      else $error("output word overwritten while stalled");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word accepted while one is in work");

endmodule

// ===== verif/byte_plane_point_read_rect_fill_top_tb.sv =====
// self-checking testbench for the byte plane point read and rectangle fill block
`timescale 1ns / 1ps

module byte_plane_point_read_rect_fill_top_tb;
   import bprf_pkg::*;

   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int BIG_FILL_AREA   = 4096;
   localparam int BIG_FILLS_MAX   = 2;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 8;
   localparam int DIRECTED_COUNT  = 25;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              status;
   } plane_result_type;

   typedef struct packed {
      logic               command;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] rect_width;
      logic [COORD_W-1:0] rect_height;
      logic [DATA_W-1:0]  fill_value;
      logic               known;
      logic [DATA_W-1:0]  known_value;
      logic               known_status;
   } plane_cmd_row_type;

   // rows without a known word are checked against the plane model
   localparam plane_cmd_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{CMD_READ, 16'd0,     16'd0,     16'd0,      16'd0,      8'h00, 1'b1, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd255,   16'd255,   16'd0,      16'd0,      8'h00, 1'b1, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd256,   16'd0,     16'd0,      16'd0,      8'h00, 1'b1, 8'h00,
        STATUS_OUT_OF_RANGE},
      '{CMD_READ, 16'd0,     16'd256,   16'd0,      16'd0,      8'h00, 1'b1, 8'h00,
        STATUS_OUT_OF_RANGE},
      '{CMD_READ, 16'hFFFF,  16'hFFFF,  16'hFFFF,   16'hFFFF,   8'hFF, 1'b1, 8'h00,
        STATUS_OUT_OF_RANGE},
      '{CMD_FILL, 16'd256,   16'd0,     16'd1,      16'd1,      8'hFF, 1'b1, 8'h00,
        STATUS_OUT_OF_RANGE},
      '{CMD_FILL, 16'd0,     16'hFFFF,  16'd1,      16'd1,      8'hFF, 1'b1, 8'h00,
        STATUS_OUT_OF_RANGE},
      '{CMD_FILL, 16'd0,     16'd0,     16'd0,      16'd5,      8'hFF, 1'b1, 8'h00,
        STATUS_DONE},
      '{CMD_FILL, 16'd0,     16'd0,     16'd5,      16'd0,      8'hFF, 1'b1, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd0,     16'd0,     16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_FILL, 16'd250,   16'd250,   16'hFFFF,   16'hFFFF,   8'hA5, 1'b1, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd255,   16'd255,   16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd249,   16'd255,   16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd250,   16'd249,   16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_FILL, 16'd0,     16'd0,     16'd4,      16'd2,      8'h5A, 1'b1, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd3,     16'd1,     16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd4,     16'd1,     16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd3,     16'd2,     16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_FILL, 16'd255,   16'd255,   16'd1,      16'd1,      8'h00, 1'b1, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd255,   16'd255,   16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_FILL, 16'd0,     16'd0,     16'hFFFF,   16'hFFFF,   8'hFF, 1'b1, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd128,   16'd77,    16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd0,     16'd255,   16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE},
      '{CMD_FILL, 16'd17,    16'd3,     16'd2,      16'd3,      8'h00, 1'b1, 8'h00,
        STATUS_DONE},
      '{CMD_READ, 16'd18,    16'd5,     16'd0,      16'd0,      8'h00, 1'b0, 8'h00,
        STATUS_DONE}
   };

   // size register values per phase, zero and values above 256 included
   localparam int PHASE_WIDTH  [PHASES] = '{16, 0, 511, 1, 256, 200, 3, 257};
   localparam int PHASE_HEIGHT [PHASES] = '{16, 511, 0, 1, 256, 7, 200, 100};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_PLANE_WIDTH;
   logic [SIZE_W-1:0]    csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_command = CMD_READ;
   logic [COORD_W-1:0]   req_x = '0;
   logic [COORD_W-1:0]   req_y = '0;
   logic [COORD_W-1:0]   req_rect_width = '0;
   logic [COORD_W-1:0]   req_rect_height = '0;
   logic [DATA_W-1:0]    req_fill_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DATA_W-1:0]    rsp_read_value;
   logic                 rsp_status;

   logic [DATA_W-1:0] plane_mem [0:65535];
   logic [SIZE_W-1:0] plane_w_reg = SIZE_RESET;
   logic [SIZE_W-1:0] plane_h_reg = SIZE_RESET;
   plane_result_type  pending_results [$];

   int   tx_idle_pct = 0;
   int   rx_stall_pct = 0;
   logic rx_hold = 1'b0;
   logic hold_trigger = 1'b0;
   int   mismatch_count = 0;
   int   cycle_count = 0;

   byte_plane_point_read_rect_fill_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_x           (req_x),
      .req_y           (req_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_fill_value  (req_fill_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status)
   );

   always #6 clock = ~clock;

   // size in use: zero acts as one, anything above the maximum as the maximum
   function automatic int plane_extent(input logic [SIZE_W-1:0] size_reg, input int top);
      if (size_reg == '0) return 1;
      if (int'(size_reg) > top) return top;
      return int'(size_reg);
   endfunction

   function automatic plane_result_type apply_plane_command(
      input logic               cmd,
      input logic [COORD_W-1:0] x,
      input logic [COORD_W-1:0] y,
      input logic [COORD_W-1:0] rw,
      input logic [COORD_W-1:0] rh,
      input logic [DATA_W-1:0]  val
   );
      int               w;
      int               h;
      int               cols;
      int               rows;
      int               xi;
      int               yi;
      plane_result_type res;
      w = plane_extent(plane_w_reg, MAX_WIDTH_DEFAULT);
      h = plane_extent(plane_h_reg, MAX_HEIGHT_DEFAULT);
      xi = int'(x);
      yi = int'(y);
      res.read_value = '0;
      res.status = STATUS_DONE;
      if (xi >= w || yi >= h) begin
         res.status = STATUS_OUT_OF_RANGE;
         return res;
      end
      if (cmd == CMD_READ) begin
         res.read_value = plane_mem[yi * w + xi];
         return res;
      end
      cols = (int'(rw) < w - xi) ? int'(rw) : w - xi;
      rows = (int'(rh) < h - yi) ? int'(rh) : h - yi;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            plane_mem[(yi + r) * w + xi + c] = val;
         end
      end
      return res;
   endfunction

   // mostly inside the plane, with edges and wild values mixed in
   function automatic logic [COORD_W-1:0] pick_coord(input int extent);
      case ($urandom_range(7, 0))
         0: begin
            return COORD_W'($urandom_range(65535, 0));
         end
         1: begin
            return COORD_W'(extent - 1);
         end
         2: begin
            return COORD_W'(extent);
         end
         default: begin
            return COORD_W'($urandom_range(extent - 1, 0));
         end
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_span();
      case ($urandom_range(7, 0))
         0: begin
            return COORD_W'($urandom_range(65535, 0));
         end
         1: begin
            return '0;
         end
         2: begin
            return '1;
         end
         default: begin
            return COORD_W'($urandom_range(12, 1));
         end
      endcase
   endfunction

   task automatic send_command(
      input logic               cmd,
      input logic [COORD_W-1:0] x,
      input logic [COORD_W-1:0] y,
      input logic [COORD_W-1:0] rw,
      input logic [COORD_W-1:0] rh,
      input logic [DATA_W-1:0]  val,
      input logic               known,
      input plane_result_type   known_result
   );
      plane_result_type model_result;
      while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_x           <= x;
      req_y           <= y;
      req_rect_width  <= rw;
      req_rect_height <= rh;
      req_fill_value  <= val;
      do @(posedge clock); while (req_stall);
      model_result = apply_plane_command(cmd, x, y, rw, rh, val);
      pending_results.push_back(known ? known_result : model_result);
      @(negedge clock);
   endtask

   task automatic wait_plane_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_plane_size(input int w, input int h);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_PLANE_WIDTH;
      csr_write_data   <= SIZE_W'(w);
      @(negedge clock);
      csr_index        <= REG_PLANE_HEIGHT;
      csr_write_data   <= SIZE_W'(h);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      plane_w_reg = SIZE_W'(w);
      plane_h_reg = SIZE_W'(h);
   endtask

   always @(negedge clock) begin
      rsp_stall <= rx_hold || ($urandom_range(99, 0) < rx_stall_pct);
   end

   // long receiver hold-off so that the block backs up into its input
   initial begin
      wait (hold_trigger);
      @(posedge clock);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold = 1'b0;
   end

   always @(posedge clock) begin
      plane_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: value %0h status %0d", rsp_read_value, rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_value !== want.read_value || rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("word mismatch: expected value %0h status %0d, got value %0h status %0d",
                           want.read_value, want.status, rsp_read_value, rsp_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("byte_plane_point_read_rect_fill_top regression: fail");
         $finish;
      end
   end

   initial begin
      plane_cmd_row_type  row;
      plane_result_type   known_result;
      logic               cmd;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] rw;
      logic [COORD_W-1:0] rh;
      logic [DATA_W-1:0]  val;
      int                 eff_w;
      int                 eff_h;
      int                 cols;
      int                 rows;
      int                 big_fills;

      big_fills = 0;
      for (int i = 0; i < 65536; i++) plane_mem[i] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed rows at the reset size, after the clearing pass
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         known_result.read_value = row.known_value;
         known_result.status = row.known_status;
         send_command(row.command, row.x, row.y, row.rect_width, row.rect_height,
                      row.fill_value, row.known, known_result);
      end

      known_result = '0;
      for (int p = 0; p < PHASES; p++) begin
         wait_plane_idle();
         write_plane_size(PHASE_WIDTH[p], PHASE_HEIGHT[p]);
         case (p % 4)
            0: begin
               tx_idle_pct = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct = 69;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct = 0;
               rx_stall_pct = 69;
            end
            default: begin
               tx_idle_pct = 36;
               rx_stall_pct = 36;
            end
         endcase
         if (p == 4) hold_trigger = 1'b1;
         eff_w = plane_extent(plane_w_reg, MAX_WIDTH_DEFAULT);
         eff_h = plane_extent(plane_h_reg, MAX_HEIGHT_DEFAULT);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            cmd = ($urandom_range(1, 0) == 0) ? CMD_READ : CMD_FILL;
            x   = pick_coord(eff_w);
            y   = pick_coord(eff_h);
            rw  = pick_span();
            rh  = pick_span();
            val = DATA_W'($urandom_range(255, 0));
            // keep the one-byte-per-cycle fills from eating the run
            if (cmd == CMD_FILL && int'(x) < eff_w && int'(y) < eff_h) begin
               cols = (int'(rw) < eff_w - int'(x)) ? int'(rw) : eff_w - int'(x);
               rows = (int'(rh) < eff_h - int'(y)) ? int'(rh) : eff_h - int'(y);
               if (cols * rows > BIG_FILL_AREA) begin
                  if (big_fills < BIG_FILLS_MAX) big_fills++;
                  else rh = COORD_W'($urandom_range(3, 0));
               end
            end
            send_command(cmd, x, y, rw, rh, val, 1'b0, known_result);
         end
      end

      wait_plane_idle();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("byte_plane_point_read_rect_fill_top regression: pass");
      end else begin
         $display("byte_plane_point_read_rect_fill_top regression: fail");
      end
      $finish;
   end

endmodule
